### hw/rtl/complex_sample_agc_unit_macros.svh
// Assertion macros for the complex sample AGC unit.
// Used by the top level only; needs nothing else.
`ifndef COMPLEX_SAMPLE_AGC_UNIT_MACROS_SVH
`define COMPLEX_SAMPLE_AGC_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSAGC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CSAGC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/csagc_pkg.sv
// Shared types and constants of the complex sample AGC unit.
// No dependencies; the interfaces, multiplier, square root and top level refer to it by scoped names.
package csagc_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int GAIN_WIDTH   = 32;
    localparam int GAIN_FRAC    = 16;
    localparam int FRAC_BITS    = SAMPLE_WIDTH - 1;
    localparam int GROUP_SIZE   = 4;
    localparam int PHASE_WIDTH  = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_WIDTH  = GAIN_WIDTH + 2;
    localparam int MUL_B_WIDTH  = SAMPLE_WIDTH + 2;
    localparam int PROD_WIDTH   = MUL_A_WIDTH + MUL_B_WIDTH;

    // Square root: power word, root and iteration count.
    localparam int PWR_WIDTH    = 2 * SAMPLE_WIDTH;
    localparam int ROOT_WIDTH   = SAMPLE_WIDTH;
    localparam int SQRT_STEPS   = SAMPLE_WIDTH;
    localparam int SQRT_CNT_W   = $clog2(SQRT_STEPS);

    // Loop error: half scale minus magnitude, one bit wider than a sample.
    localparam int ERR_WIDTH    = SAMPLE_WIDTH + 1;

    // Configuration register indexes.
    localparam int CFG_IDX_WIDTH = 2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_MIN_GAIN = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_MAX_GAIN = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ALPHA    = 2'd2;

    // Reset values.
    localparam logic [GAIN_WIDTH-1:0] RST_MIN_GAIN = 32'd1;
    localparam logic [GAIN_WIDTH-1:0] RST_MAX_GAIN = 32'hFFFF_FFFF;
    localparam logic [GAIN_WIDTH-1:0] RST_ALPHA    = 32'd429497;
    localparam logic [GAIN_WIDTH-1:0] RST_GAIN     = 32'd65536;

    // Upper bound on the root the square root can return for two saturated samples.
    localparam logic [ROOT_WIDTH-1:0] ROOT_LIMIT   = 16'd46341;

    typedef struct packed {
        logic busy;
        logic done;
    } t_sqrt_status;

endpackage

### hw/rtl/csagc_if.sv
// Handshake interfaces of the complex sample AGC unit: input, output, configuration.
// Depends on csagc_pkg for field widths.
interface csagc_in_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [csagc_pkg::SAMPLE_WIDTH-1:0] in_i;
    logic signed [csagc_pkg::SAMPLE_WIDTH-1:0] in_q;
    logic                                      block_start;

    modport source (output valid, in_i, in_q, block_start, input ready);
    modport sink   (input valid, in_i, in_q, block_start, output ready);
endinterface

interface csagc_out_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [csagc_pkg::SAMPLE_WIDTH-1:0] out_i;
    logic signed [csagc_pkg::SAMPLE_WIDTH-1:0] out_q;

    modport source (output valid, out_i, out_q, input ready);
    modport sink   (input valid, out_i, out_q, output ready);
endinterface

interface csagc_cfg_if;
    logic                                    valid;
    logic                                    ready;
    logic [csagc_pkg::CFG_IDX_WIDTH-1:0]     index;
    logic [csagc_pkg::GAIN_WIDTH-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/csagc_mul.sv
// Shared signed multiplier of the AGC unit with a registered product.
// Depends on csagc_pkg for operand widths.
module csagc_mul (
    input  logic                                     i_clk,
    input  logic signed [csagc_pkg::MUL_A_WIDTH-1:0] i_a,
    input  logic signed [csagc_pkg::MUL_B_WIDTH-1:0] i_b,
    output logic signed [csagc_pkg::PROD_WIDTH-1:0]  o_prod
);

    logic signed [csagc_pkg::PROD_WIDTH-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= csagc_pkg::PROD_WIDTH'(i_a) * csagc_pkg::PROD_WIDTH'(i_b);
    end

    assign o_prod = r_prod;

endmodule

### hw/rtl/csagc_isqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on csagc_pkg for widths and the status struct.
module csagc_isqrt (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [csagc_pkg::PWR_WIDTH-1:0]      i_radicand,
    output logic [csagc_pkg::ROOT_WIDTH-1:0]     o_root,
    output csagc_pkg::t_sqrt_status              o_stat
);

    localparam int PW = csagc_pkg::PWR_WIDTH;

    logic [PW-1:0]                       r_x;
    logic [PW-1:0]                       r_root;
    logic [PW-1:0]                       r_bit;
    logic [csagc_pkg::SQRT_CNT_W-1:0]    r_cnt;
    logic                                r_busy;
    logic                                r_done;
    logic [PW:0]                         trial;
    logic                                fits;

    assign trial = {1'b0, r_root} + {1'b0, r_bit};
    assign fits  = {1'b0, r_x} >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == csagc_pkg::SQRT_CNT_W'(csagc_pkg::SQRT_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: restoring square root, two radicand bits per step.
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_x    <= i_radicand;
            r_root <= '0;
            r_bit  <= PW'(1) << (PW - 2);
        end else if (r_busy) begin
            if (fits) begin
                r_x    <= r_x - trial[PW-1:0];
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_root      = r_root[csagc_pkg::ROOT_WIDTH-1:0];
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

### hw/rtl/complex_sample_agc_unit.sv
// Complex sample AGC unit: scales I/Q by a Q16.16 gain and adapts the gain once per group.
// A result is offered once its request has passed the MUL_I, MUL_Q, SAT_Q and OUT states, later while it stalls.
// A new sample is taken only when the sequencer is idle; a group-leading sample also holds the unit
// through both squares on the shared multiplier, the one-bit-per-cycle square root and the loop update.
// Reset (i_rst_n, synchronous, active low) restores unity gain, group phase zero and the
// default min_gain, max_gain and alpha registers, and drops any pending result.
module complex_sample_agc_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    csagc_in_if.sink   i_in,
    csagc_out_if.source o_out,
    csagc_cfg_if.sink  i_cfg
);

`include "complex_sample_agc_unit_macros.svh"

    localparam int SW   = csagc_pkg::SAMPLE_WIDTH;
    localparam int GW   = csagc_pkg::GAIN_WIDTH;
    localparam int AW   = csagc_pkg::MUL_A_WIDTH;
    localparam int BW   = csagc_pkg::MUL_B_WIDTH;
    localparam int PRW  = csagc_pkg::PROD_WIDTH;
    localparam int PHW  = csagc_pkg::PHASE_WIDTH;
    localparam int EW   = csagc_pkg::ERR_WIDTH;
    localparam int SHW  = PRW - csagc_pkg::GAIN_FRAC;
    // Loop delta is alpha * err scaled down by 2^(16 + fraction bits).
    localparam int DSH  = csagc_pkg::GAIN_FRAC + csagc_pkg::FRAC_BITS;
    localparam int DW   = PRW - DSH;

    // The sequencer walks one request through the shared multiplier: I, then Q,
    // then, for a group-leading sample, both squares, the square root and the
    // loop update.
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_I,
        S_MUL_Q,
        S_SAT_Q,
        S_OUT,
        S_SQ_I,
        S_SQ_Q,
        S_PWR,
        S_SQRT_GO,
        S_SQRT,
        S_ALPHA,
        S_UPD
    } t_state;

    t_state                    r_state;
    logic [GW-1:0]             r_min_gain;
    logic [GW-1:0]             r_max_gain;
    logic [GW-1:0]             r_alpha;
    logic [GW-1:0]             r_gain;
    logic [GW-1:0]             r_next_gain;
    logic [PHW-1:0]            r_phase;
    logic                      r_lead;
    logic signed [SW-1:0]      r_si;
    logic signed [SW-1:0]      r_sq;
    logic signed [SW-1:0]      r_oi;
    logic signed [SW-1:0]      r_oq;
    logic [csagc_pkg::PWR_WIDTH-1:0] r_pwr;
    logic signed [EW-1:0]      r_err;
    logic                      r_out_valid;
    logic signed [SW-1:0]      r_out_i;
    logic signed [SW-1:0]      r_out_q;

    logic                      in_acc;
    logic [PHW-1:0]            eff_phase;
    logic [PHW-1:0]            n_phase;
    logic signed [AW-1:0]      mul_a;
    logic signed [BW-1:0]      mul_b;
    logic signed [PRW-1:0]     prod;
    logic signed [SW-1:0]      prod_sat;
    logic signed [DW-1:0]      delta;
    logic signed [AW-1:0]      g_sum;
    logic signed [AW-1:0]      g_min;
    logic signed [AW-1:0]      g_max;
    logic [GW-1:0]             n_next_gain;
    logic                      sqrt_start;
    logic [csagc_pkg::ROOT_WIDTH-1:0] sqrt_root;
    csagc_pkg::t_sqrt_status   sqrt_stat;
    logic                      out_load;

    // Floor the Q16.16-scaled product back to Q1.15 and saturate.
    function automatic logic signed [SW-1:0] sat_sample(input logic signed [SHW-1:0] v);
        logic signed [SHW-1:0] hi;
        logic signed [SHW-1:0] lo;
        hi = SHW'(signed'({1'b0, {(SW-1){1'b1}}}));
        lo = -hi - SHW'(1);
        if (v > hi) begin
            sat_sample = {1'b0, {(SW-1){1'b1}}};
        end else if (v < lo) begin
            sat_sample = {1'b1, {(SW-1){1'b0}}};
        end else begin
            sat_sample = v[SW-1:0];
        end
    endfunction

    // Configuration writes are always taken; an index past the list is ignored.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_gain <= csagc_pkg::RST_MIN_GAIN;
            r_max_gain <= csagc_pkg::RST_MAX_GAIN;
            r_alpha    <= csagc_pkg::RST_ALPHA;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                csagc_pkg::REG_MIN_GAIN: r_min_gain <= i_cfg.data;
                csagc_pkg::REG_MAX_GAIN: r_max_gain <= i_cfg.data;
                csagc_pkg::REG_ALPHA:    r_alpha    <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // A request is taken only while the sequencer is idle.
    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;

    // A block start forces the sample to open a new group.
    assign eff_phase = i_in.block_start ? '0 : r_phase;
    assign n_phase   = (eff_phase == PHW'(csagc_pkg::GROUP_SIZE - 1)) ? '0
                                                                     : eff_phase + 1'b1;

    // Operand selection for the shared multiplier; the product shows up one
    // state later.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MUL_I: begin
                mul_a = signed'({2'b00, r_gain});
                mul_b = BW'(r_si);
            end
            S_MUL_Q: begin
                mul_a = signed'({2'b00, r_gain});
                mul_b = BW'(r_sq);
            end
            S_SQ_I: begin
                mul_a = AW'(r_oi);
                mul_b = BW'(r_oi);
            end
            S_SQ_Q: begin
                mul_a = AW'(r_oq);
                mul_b = BW'(r_oq);
            end
            S_ALPHA: begin
                mul_a = signed'({2'b00, r_alpha});
                mul_b = BW'(r_err);
            end
            default: ;
        endcase
    end

    csagc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign prod_sat = sat_sample(prod[PRW-1:csagc_pkg::GAIN_FRAC]);

    // Gain update: add the floored loop step, raise to min_gain, then lower to
    // max_gain, so max_gain wins when the two cross.
    assign delta = prod[PRW-1:DSH];
    assign g_sum = signed'({2'b00, r_gain}) + AW'(delta);
    assign g_min = signed'({2'b00, r_min_gain});
    assign g_max = signed'({2'b00, r_max_gain});

    always_comb begin
        n_next_gain = g_sum[GW-1:0];
        if (g_sum < g_min) begin
            n_next_gain = r_min_gain;
        end
        if ((g_sum < g_min ? g_min : g_sum) > g_max) begin
            n_next_gain = r_max_gain;
        end
    end

    assign sqrt_start = (r_state == S_SQRT_GO);

    csagc_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (r_pwr),
        .o_root     (sqrt_root),
        .o_stat     (sqrt_stat)
    );

    // The result register is loaded once the previous result has been taken.
    assign out_load = (r_state == S_OUT) && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gain      <= csagc_pkg::RST_GAIN;
            r_next_gain <= csagc_pkg::RST_GAIN;
            r_phase     <= '0;
            r_lead      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_lead  <= (eff_phase == '0);
                        r_phase <= n_phase;
                        if (eff_phase == '0) begin
                            r_gain <= r_next_gain;
                        end
                        r_state <= S_MUL_I;
                    end
                end
                S_MUL_I:   r_state <= S_MUL_Q;
                S_MUL_Q:   r_state <= S_SAT_Q;
                S_SAT_Q:   r_state <= S_OUT;
                S_OUT: begin
                    if (out_load) begin
                        r_state <= r_lead ? S_SQ_I : S_IDLE;
                    end
                end
                S_SQ_I:    r_state <= S_SQ_Q;
                S_SQ_Q:    r_state <= S_PWR;
                S_PWR:     r_state <= S_SQRT_GO;
                S_SQRT_GO: r_state <= S_SQRT;
                S_SQRT: begin
                    if (sqrt_stat.done) begin
                        r_state <= S_ALPHA;
                    end
                end
                S_ALPHA:   r_state <= S_UPD;
                S_UPD: begin
                    r_next_gain <= n_next_gain;
                    r_state     <= S_IDLE;
                end
                default:   r_state <= S_IDLE;
            endcase
        end
    end

    // Payload registers along the sequence.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_si <= i_in.in_i;
            r_sq <= i_in.in_q;
        end
        if (r_state == S_MUL_Q) begin
            r_oi <= prod_sat;
        end
        if (r_state == S_SAT_Q) begin
            r_oq <= prod_sat;
        end
        if (r_state == S_SQ_Q) begin
            r_pwr <= prod[csagc_pkg::PWR_WIDTH-1:0];
        end
        if (r_state == S_PWR) begin
            r_pwr <= r_pwr + prod[csagc_pkg::PWR_WIDTH-1:0];
        end
        if ((r_state == S_SQRT) && sqrt_stat.done) begin
            // Error is half scale minus the magnitude.
            r_err <= EW'(1 << (csagc_pkg::FRAC_BITS - 1)) - signed'({1'b0, sqrt_root});
        end
        if (out_load) begin
            r_out_i <= r_oi;
            r_out_q <= r_oq;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.out_i = r_out_i;
    assign o_out.out_q = r_out_q;

    `CSAGC_ASSERT_IMP(a_out_from_seq, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == S_OUT), "result raised outside the output step")
    `CSAGC_ASSERT_IMP(a_sqrt_idle_start, i_clk, i_rst_n, sqrt_start, !sqrt_stat.busy, "square root started while busy")
    `CSAGC_ASSERT_IMP(a_root_range, i_clk, i_rst_n, sqrt_stat.done, sqrt_root <= csagc_pkg::ROOT_LIMIT, "square root out of range")
    `CSAGC_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, in_acc, r_state == S_MUL_I, "accepted request did not start the multiply")

endmodule
